FILE: hw/rtl/pbpa_pkg.sv
package pbpa_pkg;

  // Field widths of the words on the two channels.
  localparam int CMD_W    = 3;
  localparam int SLOT_W   = 10;
  localparam int PAGE_W   = 4;
  localparam int SIZE_W   = 17;
  localparam int STATUS_W = 2;
  localparam int OFF_W    = 22;
  localparam int CAP_W    = 7;

  // Free stack geometry.
  localparam int STK_DEPTH = 1024;
  localparam int STK_AW    = 10;
  localparam int CNT_W     = 11;

  // Offset product: in-page slot times block size.
  localparam int PROD_W = CAP_W + SIZE_W;

  // Register port.
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // Microprogram counter width.
  localparam int UPC_W = 5;

  // Register indexes (word address bit of paddr).
  localparam logic REG_BLOCK_SIZE = 1'b0;
  localparam logic REG_PAGE_CAP   = 1'b1;

  // Register reset values and limits.
  localparam logic [SIZE_W-1:0] BLK_RESET = 17'd256;
  localparam logic [SIZE_W-1:0] BLK_MAX   = 17'd65536;
  localparam logic [CAP_W-1:0]  CAP_RESET = 7'd64;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MAP     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UNMAP   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_PAGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD     = 2'd2;

  // Datapath operation selected by one control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_FILL_INIT,
    OP_FILL,
    OP_FILL_END,
    OP_POP_RD,
    OP_GRAB,
    OP_DIV_START,
    OP_DIV_WAIT,
    OP_MUL,
    OP_PUSH,
    OP_SETFLAG,
    OP_EMIT_OK,
    OP_EMIT_ERR1,
    OP_EMIT_ERR2
  } op_t;

  // Jump condition selected by one control word.
  typedef enum logic [3:0] {
    C_ALWAYS,
    C_IN_FIRE,
    C_IS_ALLOC,
    C_IS_REL,
    C_IS_MAP,
    C_IS_QRY,
    C_STACK_EMPTY,
    C_PAGES_FULL,
    C_FILL_LAST,
    C_DIV_MORE,
    C_REL_BAD,
    C_PAGE_BAD,
    C_SLOT_BAD,
    C_OUT_BUSY
  } cond_sel_t;

  // One control word of the microprogram.
  typedef struct packed {
    op_t              op;
    cond_sel_t        cond;
    logic             neg;
    logic             ret;
    logic [UPC_W-1:0] target;
  } cw_t;

  // Status flags from the datapath that the sequencer branches on.
  typedef struct packed {
    logic in_fire;
    logic is_alloc;
    logic is_rel;
    logic is_map;
    logic is_qry;
    logic stack_empty;
    logic pages_full;
    logic fill_last;
    logic div_more;
    logic rel_bad;
    logic page_bad;
    logic slot_bad;
    logic out_busy;
  } cond_t;

endpackage

FILE: hw/rtl/pbpa_ram.sv
module pbpa_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/pbpa_div.sv
module pbpa_div #(
  parameter int N = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [N-1:0]               dividend,
  input  logic [pbpa_pkg::CAP_W-1:0] divisor,
  output logic                       more,
  output logic [N-1:0]               quot,
  output logic [pbpa_pkg::CAP_W-1:0] rem
);
  import pbpa_pkg::*;

  // Two quotient bits per cycle over a dividend padded to even width.
  localparam int ITER = (N + 1) / 2;
  localparam int NP   = 2 * ITER;
  localparam int CW   = $clog2(ITER + 1);

  logic              busy_r;
  logic [CW-1:0]     cnt_r;
  logic [NP-1:0]     q_r;
  logic [CAP_W-1:0]  r_r;
  logic [CAP_W-1:0]  d_r;
  logic [CAP_W:0]    s1;
  logic [CAP_W:0]    s2;

  // One restoring step: returns the quotient bit over the new remainder.
  function automatic logic [CAP_W:0] dstep(input logic [CAP_W-1:0] r, input logic b,
                                           input logic [CAP_W-1:0] d);
    logic [CAP_W:0] t;
    logic [CAP_W:0] diff;
    t    = {r, b};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      dstep = {1'b1, diff[CAP_W-1:0]};
    end else begin
      dstep = {1'b0, t[CAP_W-1:0]};
    end
  endfunction

  assign s1 = dstep(r_r, q_r[NP-1], d_r);
  assign s2 = dstep(s1[CAP_W-1:0], q_r[NP-2], d_r);

  // Iteration control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(ITER);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= (cnt_r != CW'(1));
    end
  end

  // Shift the dividend out and the quotient in.
  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= NP'(dividend);
      r_r <= '0;
      d_r <= divisor;
    end else if (busy_r) begin
      q_r <= {q_r[NP-3:0], s1[CAP_W], s2[CAP_W]};
      r_r <= s2[CAP_W-1:0];
    end
  end

  // High while iterations remain after the current one.
  assign more = busy_r && (cnt_r != CW'(1));
  assign quot = q_r[N-1:0];
  assign rem  = r_r;

endmodule

FILE: hw/rtl/pbpa_seq.sv
module pbpa_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  pbpa_pkg::cond_t cond,
  output pbpa_pkg::op_t   op
);
  import pbpa_pkg::*;

  // Entry points of the microprogram.
  localparam logic [UPC_W-1:0] S_IDLE   = 5'd0;
  localparam logic [UPC_W-1:0] S_ALLOC  = 5'd6;
  localparam logic [UPC_W-1:0] S_FILL   = 5'd9;
  localparam logic [UPC_W-1:0] S_POP    = 5'd11;
  localparam logic [UPC_W-1:0] S_DIV    = 5'd13;
  localparam logic [UPC_W-1:0] S_DWAIT  = 5'd14;
  localparam logic [UPC_W-1:0] S_EMIT   = 5'd16;
  localparam logic [UPC_W-1:0] S_REL    = 5'd17;
  localparam logic [UPC_W-1:0] S_MAP    = 5'd19;
  localparam logic [UPC_W-1:0] S_QRY    = 5'd21;
  localparam logic [UPC_W-1:0] S_ERR2   = 5'd22;
  localparam logic [UPC_W-1:0] S_ERR1   = 5'd23;

  logic [UPC_W-1:0] upc_r;
  logic [UPC_W-1:0] upc_nxt;
  cw_t              cw;
  logic             cval;

  function automatic cw_t mk(input op_t o, input cond_sel_t c, input logic n,
                             input logic r, input logic [UPC_W-1:0] t);
    cw_t w;
    w.op     = o;
    w.cond   = c;
    w.neg    = n;
    w.ret    = r;
    w.target = t;
    return w;
  endfunction

  // Control store: one word per step.
  function automatic cw_t ucode(input logic [UPC_W-1:0] a);
    case (a)
      5'd0:    ucode = mk(OP_ACCEPT,    C_IN_FIRE,     1'b1, 1'b0, S_IDLE);
      5'd1:    ucode = mk(OP_NOP,       C_IS_ALLOC,    1'b0, 1'b0, S_ALLOC);
      5'd2:    ucode = mk(OP_NOP,       C_IS_REL,      1'b0, 1'b0, S_REL);
      5'd3:    ucode = mk(OP_NOP,       C_IS_MAP,      1'b0, 1'b0, S_MAP);
      5'd4:    ucode = mk(OP_NOP,       C_IS_QRY,      1'b0, 1'b0, S_QRY);
      5'd5:    ucode = mk(OP_NOP,       C_ALWAYS,      1'b0, 1'b0, S_ERR2);
      5'd6:    ucode = mk(OP_NOP,       C_STACK_EMPTY, 1'b1, 1'b0, S_POP);
      5'd7:    ucode = mk(OP_NOP,       C_PAGES_FULL,  1'b0, 1'b0, S_ERR1);
      5'd8:    ucode = mk(OP_FILL_INIT, C_ALWAYS,      1'b1, 1'b0, S_IDLE);
      5'd9:    ucode = mk(OP_FILL,      C_FILL_LAST,   1'b1, 1'b0, S_FILL);
      5'd10:   ucode = mk(OP_FILL_END,  C_ALWAYS,      1'b1, 1'b0, S_IDLE);
      5'd11:   ucode = mk(OP_POP_RD,    C_ALWAYS,      1'b1, 1'b0, S_IDLE);
      5'd12:   ucode = mk(OP_GRAB,      C_ALWAYS,      1'b1, 1'b0, S_IDLE);
      5'd13:   ucode = mk(OP_DIV_START, C_ALWAYS,      1'b1, 1'b0, S_IDLE);
      5'd14:   ucode = mk(OP_DIV_WAIT,  C_DIV_MORE,    1'b0, 1'b0, S_DWAIT);
      5'd15:   ucode = mk(OP_MUL,       C_ALWAYS,      1'b1, 1'b0, S_IDLE);
      5'd16:   ucode = mk(OP_EMIT_OK,   C_OUT_BUSY,    1'b0, 1'b1, S_EMIT);
      5'd17:   ucode = mk(OP_NOP,       C_REL_BAD,     1'b0, 1'b0, S_ERR2);
      5'd18:   ucode = mk(OP_PUSH,      C_ALWAYS,      1'b0, 1'b0, S_DIV);
      5'd19:   ucode = mk(OP_NOP,       C_PAGE_BAD,    1'b0, 1'b0, S_ERR2);
      5'd20:   ucode = mk(OP_SETFLAG,   C_ALWAYS,      1'b0, 1'b0, S_EMIT);
      5'd21:   ucode = mk(OP_NOP,       C_SLOT_BAD,    1'b1, 1'b0, S_DIV);
      5'd22:   ucode = mk(OP_EMIT_ERR2, C_OUT_BUSY,    1'b0, 1'b1, S_ERR2);
      5'd23:   ucode = mk(OP_EMIT_ERR1, C_OUT_BUSY,    1'b0, 1'b1, S_ERR1);
      default: ucode = mk(OP_NOP,       C_ALWAYS,      1'b0, 1'b0, S_IDLE);
    endcase
  endfunction

  assign cw = ucode(upc_r);
  assign op = cw.op;

  // Condition select.
  always_comb begin
    case (cw.cond)
      C_ALWAYS:      cval = 1'b1;
      C_IN_FIRE:     cval = cond.in_fire;
      C_IS_ALLOC:    cval = cond.is_alloc;
      C_IS_REL:      cval = cond.is_rel;
      C_IS_MAP:      cval = cond.is_map;
      C_IS_QRY:      cval = cond.is_qry;
      C_STACK_EMPTY: cval = cond.stack_empty;
      C_PAGES_FULL:  cval = cond.pages_full;
      C_FILL_LAST:   cval = cond.fill_last;
      C_DIV_MORE:    cval = cond.div_more;
      C_REL_BAD:     cval = cond.rel_bad;
      C_PAGE_BAD:    cval = cond.page_bad;
      C_SLOT_BAD:    cval = cond.slot_bad;
      C_OUT_BUSY:    cval = cond.out_busy;
      default:       cval = 1'b0;
    endcase
  end

  // Next step: jump when taken, back to idle on a return word, else fall through.
  always_comb begin
    if (cval ^ cw.neg) begin
      upc_nxt = cw.target;
    end else if (cw.ret) begin
      upc_nxt = S_IDLE;
    end else begin
      upc_nxt = upc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

FILE: hw/rtl/pbpa_dpath.sv
module pbpa_dpath #(
  parameter int MAX_PAGES      = 16,
  parameter int MAX_PAGE_SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pbpa_pkg::op_t                 op,
  output pbpa_pkg::cond_t               cond,
  input  logic [pbpa_pkg::SIZE_W-1:0]   block_size,
  input  logic [pbpa_pkg::CAP_W-1:0]    page_capacity,
  input  logic                          in_valid,
  input  logic [pbpa_pkg::CMD_W-1:0]    in_cmd,
  input  logic [pbpa_pkg::SLOT_W-1:0]   in_slot_index,
  input  logic [pbpa_pkg::PAGE_W-1:0]   in_page_select,
  input  logic [pbpa_pkg::SIZE_W-1:0]   in_requested_size,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pbpa_pkg::STATUS_W-1:0] out_status,
  output logic [pbpa_pkg::SLOT_W-1:0]   out_slot_out,
  output logic [pbpa_pkg::PAGE_W-1:0]   out_page_out,
  output logic [pbpa_pkg::OFF_W-1:0]    out_byte_offset,
  output logic [pbpa_pkg::SIZE_W-1:0]   out_binding_size,
  output logic                          out_mapped
);
  import pbpa_pkg::*;

  // Stack entries hold any slot number the opened pages can produce.
  localparam int SLOT_BITS = $clog2(MAX_PAGES * MAX_PAGE_SLOTS);
  localparam int ENT_W     = (SLOT_BITS > SLOT_W) ? SLOT_BITS : SLOT_W;
  localparam int PO_W      = $clog2(MAX_PAGES + 1);
  localparam int PG_IW     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CAP_MAX   = (MAX_PAGE_SLOTS > 127) ? 127 : MAX_PAGE_SLOTS;
  localparam int OS_W      = PO_W + CAP_W;
  localparam int SC_W      = (OS_W > ENT_W) ? OS_W : ENT_W;
  localparam int PC_W      = (PO_W > PAGE_W) ? PO_W : PAGE_W;

  // Captured command word.
  logic [CMD_W-1:0]    cmd_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [PAGE_W-1:0]   psel_r;
  logic [SIZE_W-1:0]   req_r;

  // Allocator state.
  logic [CNT_W-1:0]     count_r;
  logic [PO_W-1:0]      pages_open_r;
  logic [MAX_PAGES-1:0] flags_r;

  // Working registers.
  logic [ENT_W-1:0]  val_r;
  logic [CAP_W-1:0]  fill_idx_r;
  logic [ENT_W-1:0]  fill_base_r;
  logic [PROD_W-1:0] prod_r;

  // Result register.
  logic                out_valid_r;
  logic [STATUS_W-1:0] st_r;
  logic [SLOT_W-1:0]   slot_out_r;
  logic [PAGE_W-1:0]   page_out_r;
  logic [OFF_W-1:0]    off_r;
  logic [SIZE_W-1:0]   bind_r;
  logic                map_r;

  logic [STATUS_W-1:0] st_nxt;
  logic [SLOT_W-1:0]   slot_out_nxt;
  logic [PAGE_W-1:0]   page_out_nxt;
  logic [OFF_W-1:0]    off_nxt;
  logic [SIZE_W-1:0]   bind_nxt;
  logic                map_nxt;

  logic [CAP_W-1:0]  cap;
  logic [SIZE_W-1:0] blk;
  logic [OS_W-1:0]   opened;
  logic [CNT_W-1:0]  cnt_dec;
  logic              out_busy;
  logic              emit;
  logic              is_mapcmd;
  logic [PG_IW-1:0]  psel_idx;
  logic [PG_IW-1:0]  quot_idx;
  logic [PG_IW-1:0]  flag_idx;
  logic              flag_ok;
  logic              flag_rd;

  logic              ram_we;
  logic [STK_AW-1:0] ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;
  logic [ENT_W-1:0]  ram_rdata;

  logic              div_more;
  logic [ENT_W-1:0]  quot;
  logic [CAP_W-1:0]  rem;

  // Clamped configuration.
  always_comb begin
    if (page_capacity == '0) begin
      cap = CAP_W'(1);
    end else if (page_capacity > CAP_W'(CAP_MAX)) begin
      cap = CAP_W'(CAP_MAX);
    end else begin
      cap = page_capacity;
    end
    if (block_size == '0) begin
      blk = SIZE_W'(1);
    end else if (block_size > BLK_MAX) begin
      blk = BLK_MAX;
    end else begin
      blk = block_size;
    end
  end

  assign opened  = OS_W'(pages_open_r) * OS_W'(cap);
  assign cnt_dec = count_r - 1'b1;

  // Branch conditions for the sequencer.
  assign is_mapcmd = (cmd_r == CMD_MAP) || (cmd_r == CMD_UNMAP);
  assign out_busy  = out_valid_r && out_stall;

  always_comb begin
    cond.in_fire     = in_valid && (op == OP_ACCEPT);
    cond.is_alloc    = (cmd_r == CMD_ALLOC);
    cond.is_rel      = (cmd_r == CMD_RELEASE);
    cond.is_map      = is_mapcmd;
    cond.is_qry      = (cmd_r == CMD_QUERY);
    cond.stack_empty = (count_r == '0);
    cond.pages_full  = (pages_open_r >= PO_W'(MAX_PAGES));
    cond.fill_last   = (fill_idx_r == cap - 1'b1);
    cond.div_more    = div_more;
    cond.slot_bad    = (SC_W'(slot_r) >= SC_W'(opened));
    cond.rel_bad     = cond.slot_bad || (count_r >= CNT_W'(STK_DEPTH));
    cond.page_bad    = (PC_W'(psel_r) >= PC_W'(pages_open_r)) ||
                       (PC_W'(psel_r) >= PC_W'(MAX_PAGES));
    cond.out_busy    = out_busy;
  end

  // Free stack: fill writes a new page, push writes a released slot.
  assign ram_we    = (op == OP_FILL) || (op == OP_PUSH);
  assign ram_waddr = (op == OP_FILL) ? STK_AW'(fill_idx_r) : count_r[STK_AW-1:0];
  assign ram_wdata = (op == OP_FILL) ? fill_base_r + ENT_W'(fill_idx_r) : ENT_W'(slot_r);

  pbpa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (STK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_dec[STK_AW-1:0]),
    .rdata (ram_rdata)
  );

  // Page and in-page slot of the working slot number.
  pbpa_div #(
    .N (ENT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (op == OP_DIV_START),
    .dividend (val_r),
    .divisor  (cap),
    .more     (div_more),
    .quot     (quot),
    .rem      (rem)
  );

  // Mapped flag lookup: the selected page for map and unmap, else the slot's page.
  assign psel_idx = PG_IW'(psel_r);
  assign quot_idx = PG_IW'(quot);
  assign flag_idx = is_mapcmd ? psel_idx : quot_idx;
  assign flag_ok  = is_mapcmd || (quot < ENT_W'(MAX_PAGES));
  assign flag_rd  = flag_ok && flags_r[flag_idx];

  // Allocator state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      pages_open_r <= '0;
      flags_r      <= '0;
    end else begin
      case (op)
        OP_FILL_END: begin
          count_r      <= CNT_W'(cap);
          pages_open_r <= pages_open_r + 1'b1;
        end
        OP_POP_RD: count_r <= cnt_dec;
        OP_PUSH:   count_r <= count_r + 1'b1;
        OP_SETFLAG: flags_r[psel_idx] <= (cmd_r == CMD_MAP);
        default: ;
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cond.in_fire) begin
      cmd_r  <= in_cmd;
      slot_r <= in_slot_index;
      psel_r <= in_page_select;
      req_r  <= in_requested_size;
      val_r  <= ENT_W'(in_slot_index);
    end
    case (op)
      OP_FILL_INIT: begin
        fill_idx_r  <= '0;
        fill_base_r <= ENT_W'(opened);
      end
      OP_FILL: fill_idx_r <= fill_idx_r + 1'b1;
      OP_GRAB: val_r <= ram_rdata;
      OP_MUL:  prod_r <= PROD_W'(rem) * PROD_W'(blk);
      default: ;
    endcase
  end

  // Result fields by command; an error result carries only its status.
  assign emit = (op == OP_EMIT_OK) || (op == OP_EMIT_ERR1) || (op == OP_EMIT_ERR2);

  always_comb begin
    st_nxt       = ST_OK;
    slot_out_nxt = '0;
    page_out_nxt = '0;
    off_nxt      = '0;
    bind_nxt     = '0;
    map_nxt      = 1'b0;
    case (op)
      OP_EMIT_OK: begin
        case (cmd_r)
          CMD_ALLOC: begin
            slot_out_nxt = val_r[SLOT_W-1:0];
            page_out_nxt = quot[PAGE_W-1:0];
            off_nxt      = prod_r[OFF_W-1:0];
            bind_nxt     = req_r;
            map_nxt      = flag_rd;
          end
          CMD_RELEASE, CMD_QUERY: begin
            page_out_nxt = quot[PAGE_W-1:0];
            map_nxt      = flag_rd;
          end
          CMD_MAP, CMD_UNMAP: begin
            page_out_nxt = psel_r;
            map_nxt      = flag_rd;
          end
          default: ;
        endcase
      end
      OP_EMIT_ERR1: st_nxt = ST_NO_PAGE;
      OP_EMIT_ERR2: st_nxt = ST_BAD;
      default: ;
    endcase
  end

  // Output register: loads when empty or being drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit && !out_busy) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && !out_busy) begin
      st_r       <= st_nxt;
      slot_out_r <= slot_out_nxt;
      page_out_r <= page_out_nxt;
      off_r      <= off_nxt;
      bind_r     <= bind_nxt;
      map_r      <= map_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = st_r;
  assign out_slot_out     = slot_out_r;
  assign out_page_out     = page_out_r;
  assign out_byte_offset  = off_r;
  assign out_binding_size = bind_r;
  assign out_mapped       = map_r;

endmodule

FILE: hw/rtl/paged_block_pool_allocator.sv
// Fixed-size block allocator with a LIFO free stack of slot numbers held in a
// 1024-entry RAM, run by a small microprogram. One word in gives one result word
// out. The page and in-page slot come from a shared divider that yields two
// quotient bits per cycle, followed by one multiply for the byte offset. An
// allocate that finds the stack empty first opens a page, writing one stack
// entry per cycle. A result that cannot leave holds the microprogram on its
// last step. The next word is taken while a finished result still waits in
// the output register. The stack needs no clearing after reset; only entries
// written since are ever read.
module paged_block_pool_allocator #(
  parameter int MAX_PAGES      = 16,
  parameter int MAX_PAGE_SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pbpa_pkg::ADDR_W-1:0]   paddr,
  input  logic [pbpa_pkg::DATA_W-1:0]   pwdata,
  output logic [pbpa_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pbpa_pkg::CMD_W-1:0]    in_cmd,
  input  logic [pbpa_pkg::SLOT_W-1:0]   in_slot_index,
  input  logic [pbpa_pkg::PAGE_W-1:0]   in_page_select,
  input  logic [pbpa_pkg::SIZE_W-1:0]   in_requested_size,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pbpa_pkg::STATUS_W-1:0] out_status,
  output logic [pbpa_pkg::SLOT_W-1:0]   out_slot_out,
  output logic [pbpa_pkg::PAGE_W-1:0]   out_page_out,
  output logic [pbpa_pkg::OFF_W-1:0]    out_byte_offset,
  output logic [pbpa_pkg::SIZE_W-1:0]   out_binding_size,
  output logic                          out_mapped
);
  import pbpa_pkg::*;

  logic [SIZE_W-1:0] block_size_r;
  logic [CAP_W-1:0]  page_cap_r;
  logic              wr_en;
  op_t               op;
  cond_t             cond;

  // Register writes complete in the access phase.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= BLK_RESET;
      page_cap_r   <= CAP_RESET;
    end else if (wr_en) begin
      case (paddr[ADDR_W-1])
        REG_BLOCK_SIZE: block_size_r <= pwdata[SIZE_W-1:0];
        REG_PAGE_CAP:   page_cap_r   <= pwdata[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[ADDR_W-1])
      REG_BLOCK_SIZE: prdata = DATA_W'(block_size_r);
      REG_PAGE_CAP:   prdata = DATA_W'(page_cap_r);
      default:        prdata = '0;
    endcase
  end

  // The input is open only on the idle step of the microprogram.
  assign in_stall = (op != OP_ACCEPT);

  pbpa_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .cond  (cond),
    .op    (op)
  );

  pbpa_dpath #(
    .MAX_PAGES      (MAX_PAGES),
    .MAX_PAGE_SLOTS (MAX_PAGE_SLOTS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .op                (op),
    .cond              (cond),
    .block_size        (block_size_r),
    .page_capacity     (page_cap_r),
    .in_valid          (in_valid),
    .in_cmd            (in_cmd),
    .in_slot_index     (in_slot_index),
    .in_page_select    (in_page_select),
    .in_requested_size (in_requested_size),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_slot_out      (out_slot_out),
    .out_page_out      (out_page_out),
    .out_byte_offset   (out_byte_offset),
    .out_binding_size  (out_binding_size),
    .out_mapped        (out_mapped)
  );

endmodule

FILE: tb/pbpa_checker.sv
module pbpa_checker #(
  parameter int MAX_PAGES      = 16,
  parameter int MAX_PAGE_SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [pbpa_pkg::ADDR_W-1:0]   paddr,
  input  logic [pbpa_pkg::DATA_W-1:0]   pwdata,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [pbpa_pkg::CMD_W-1:0]    in_cmd,
  input  logic [pbpa_pkg::SLOT_W-1:0]   in_slot_index,
  input  logic [pbpa_pkg::PAGE_W-1:0]   in_page_select,
  input  logic [pbpa_pkg::SIZE_W-1:0]   in_requested_size,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [pbpa_pkg::STATUS_W-1:0] out_status,
  input  logic [pbpa_pkg::SLOT_W-1:0]   out_slot_out,
  input  logic [pbpa_pkg::PAGE_W-1:0]   out_page_out,
  input  logic [pbpa_pkg::OFF_W-1:0]    out_byte_offset,
  input  logic [pbpa_pkg::SIZE_W-1:0]   out_binding_size,
  input  logic                          out_mapped,
  input  logic                          drain_done,
  output int                            fail_count,
  output int                            stack_level,
  output int                            pages_level,
  output int                            slots_level
);
  import pbpa_pkg::*;

  // One result word as the allocator should produce it.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [PAGE_W-1:0]   page;
    logic [OFF_W-1:0]    offset;
    logic [SIZE_W-1:0]   size;
    logic                mapped;
  } pool_reply_t;

  pool_reply_t          owed_replies[$];
  logic [SLOT_W-1:0]    free_slots[STK_DEPTH];
  int unsigned          free_depth = 0;
  int unsigned          pages_opened = 0;
  logic [MAX_PAGES-1:0] page_mapped = '0;
  logic [SIZE_W-1:0]    block_bytes = BLK_RESET;
  logic [CAP_W-1:0]     page_blocks = CAP_RESET;
  int                   faults = 0;

  assign fail_count = faults;

  // Capacity and block size as the block applies them, clamped to their legal ranges.
  function automatic int unsigned blocks_per_page();
    if (page_blocks == '0) return 1;
    if (page_blocks > MAX_PAGE_SLOTS) return MAX_PAGE_SLOTS;
    return page_blocks;
  endfunction

  function automatic int unsigned bytes_per_block();
    if (block_bytes == '0) return 1;
    if (block_bytes > BLK_MAX) return BLK_MAX;
    return block_bytes;
  endfunction

  // A page number past the flag array reads as unmapped.
  function automatic logic page_is_mapped(input int unsigned page_no);
    if (page_no < MAX_PAGES) return page_mapped[page_no];
    return 1'b0;
  endfunction

  // Applies one command word to the pool and works out the result word it yields.
  task automatic apply_pool_cmd(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                                input logic [PAGE_W-1:0] pg, input logic [SIZE_W-1:0] req,
                                output pool_reply_t r);
    int unsigned cap;
    int unsigned opened;
    int unsigned granted;
    int unsigned page_no;
    cap = blocks_per_page();
    opened = pages_opened * cap;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_ALLOC: begin
        // An empty stack opens the next page, pushing its slots lowest first.
        if (free_depth == 0) begin
          if (pages_opened >= MAX_PAGES) begin
            r.status = ST_NO_PAGE;
          end else begin
            for (int i = 0; i < cap; i++) free_slots[i] = SLOT_W'(opened + i);
            free_depth = cap;
            pages_opened++;
          end
        end
        if (r.status == ST_OK) begin
          free_depth--;
          granted = free_slots[free_depth];
          page_no = granted / cap;
          r.slot = SLOT_W'(granted);
          r.page = PAGE_W'(page_no);
          r.offset = OFF_W'((granted % cap) * bytes_per_block());
          r.size = req;
          r.mapped = page_is_mapped(page_no);
        end
      end
      CMD_RELEASE: begin
        if (slot >= opened || free_depth >= STK_DEPTH) begin
          r.status = ST_BAD;
        end else begin
          free_slots[free_depth] = slot;
          free_depth++;
          page_no = slot / cap;
          r.page = PAGE_W'(page_no);
          r.mapped = page_is_mapped(page_no);
        end
      end
      CMD_MAP, CMD_UNMAP: begin
        if (pg >= pages_opened || pg >= MAX_PAGES) begin
          r.status = ST_BAD;
        end else begin
          page_mapped[pg] = (cmd == CMD_MAP);
          r.page = pg;
          r.mapped = page_mapped[pg];
        end
      end
      CMD_QUERY: begin
        if (slot >= opened) begin
          r.status = ST_BAD;
        end else begin
          page_no = slot / cap;
          r.page = PAGE_W'(page_no);
          r.mapped = page_is_mapped(page_no);
        end
      end
      default: begin
        r.status = ST_BAD;
      end
    endcase
  endtask

  // Tracks register writes and accepted words, and compares each result word in order.
  always @(posedge clk) begin : track
    pool_reply_t want;
    if (!rst_n) begin
      owed_replies.delete();
      free_depth = 0;
      pages_opened = 0;
      page_mapped = '0;
      block_bytes = BLK_RESET;
      page_blocks = CAP_RESET;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_BLOCK_SIZE) begin
          block_bytes = pwdata[SIZE_W-1:0];
        end else begin
          page_blocks = pwdata[CAP_W-1:0];
        end
      end
      if (in_valid && !in_stall) begin
        apply_pool_cmd(in_cmd, in_slot_index, in_page_select, in_requested_size, want);
        owed_replies.insert(owed_replies.size(), want);
      end
      if (out_valid && !out_stall) begin
        if (owed_replies.size() == 0) begin
          $error("result word with nothing expected: status %0d slot %0d", out_status,
                 out_slot_out);
          faults++;
        end else begin
          want = owed_replies.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            faults++;
          end
          if (out_slot_out !== want.slot) begin
            $error("slot_out: expected %0d, got %0d", want.slot, out_slot_out);
            faults++;
          end
          if (out_page_out !== want.page) begin
            $error("page_out: expected %0d, got %0d", want.page, out_page_out);
            faults++;
          end
          if (out_byte_offset !== want.offset) begin
            $error("byte_offset: expected %0d, got %0d", want.offset, out_byte_offset);
            faults++;
          end
          if (out_binding_size !== want.size) begin
            $error("binding_size: expected %0d, got %0d", want.size, out_binding_size);
            faults++;
          end
          if (out_mapped !== want.mapped) begin
            $error("mapped: expected %0d, got %0d", want.mapped, out_mapped);
            faults++;
          end
        end
      end
      // Any result still owed once the run has drained is a loss.
      if (drain_done && owed_replies.size() != 0) begin
        $error("%0d result words never arrived", owed_replies.size());
        faults += owed_replies.size();
      end
    end
    stack_level <= free_depth;
    pages_level <= pages_opened;
    slots_level <= pages_opened * blocks_per_page();
  end

endmodule

FILE: tb/tb_paged_block_pool_allocator.sv
module tb_paged_block_pool_allocator;
  import pbpa_pkg::*;

  localparam int POOL_PAGES     = 16;
  localparam int POOL_SLOTS_MAX = 64;
  localparam int HOLD_CYCLES    = 300;
  localparam int STALL_LIMIT    = 3000;
  localparam int SETTLE_CYCLES  = 40;

  localparam logic [ADDR_W-1:0] ADDR_BLOCK_SIZE = {REG_BLOCK_SIZE, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_PAGE_CAP   = {REG_PAGE_CAP, 2'b00};

  // Command codes the block does not define.
  localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_MID   = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    in_cmd = '0;
  logic [SLOT_W-1:0]   in_slot_index = '0;
  logic [PAGE_W-1:0]   in_page_select = '0;
  logic [SIZE_W-1:0]   in_requested_size = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot_out;
  logic [PAGE_W-1:0]   out_page_out;
  logic [OFF_W-1:0]    out_byte_offset;
  logic [SIZE_W-1:0]   out_binding_size;
  logic                out_mapped;
  logic                drain_done = 1'b0;

  int fail_count;
  int stack_level;
  int pages_level;
  int slots_level;
  int words_sent = 0;
  int words_taken = 0;
  int idle_cycles = 0;
  int hold_asks = 0;
  int holds_served = 0;
  int send_style = 0;
  int take_style = 1;

  always #6 clk = ~clk;

  paged_block_pool_allocator #(
    .MAX_PAGES      (POOL_PAGES),
    .MAX_PAGE_SLOTS (POOL_SLOTS_MAX)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_slot_index     (in_slot_index),
    .in_page_select    (in_page_select),
    .in_requested_size (in_requested_size),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_slot_out      (out_slot_out),
    .out_page_out      (out_page_out),
    .out_byte_offset   (out_byte_offset),
    .out_binding_size  (out_binding_size),
    .out_mapped        (out_mapped)
  );

  pbpa_checker #(
    .MAX_PAGES      (POOL_PAGES),
    .MAX_PAGE_SLOTS (POOL_SLOTS_MAX)
  ) pool_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .pready            (pready),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_slot_index     (in_slot_index),
    .in_page_select    (in_page_select),
    .in_requested_size (in_requested_size),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_slot_out      (out_slot_out),
    .out_page_out      (out_page_out),
    .out_byte_offset   (out_byte_offset),
    .out_binding_size  (out_binding_size),
    .out_mapped        (out_mapped),
    .drain_done        (drain_done),
    .fail_count        (fail_count),
    .stack_level       (stack_level),
    .pages_level       (pages_level),
    .slots_level       (slots_level)
  );

  // Length of one idle stretch: mostly none, some short and a few long.
  function automatic int idle_len(input int style);
    int roll;
    roll = $urandom_range(0, 99);
    if (style == 0 || roll < 65) return 0;
    if (roll < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Slots are mostly inside the opened pages, sometimes anywhere.
  function automatic logic [SLOT_W-1:0] pick_slot();
    if (slots_level > 0 && $urandom_range(0, 99) < 85) begin
      return SLOT_W'($urandom_range(0, slots_level - 1));
    end
    return SLOT_W'($urandom);
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return SIZE_W'($urandom);
  endfunction

  // Offers one command word and holds it until the block takes it.
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                           input logic [PAGE_W-1:0] pg, input logic [SIZE_W-1:0] req);
    int gap;
    gap = idle_len(send_style);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_slot_index <= slot;
    in_page_select <= pg;
    in_requested_size <= req;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Stops offering and waits until every result word has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (words_taken != words_sent) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [DATA_W-1:0] blk, input logic [DATA_W-1:0] cap);
    settle();
    write_reg(ADDR_BLOCK_SIZE, blk);
    write_reg(ADDR_PAGE_CAP, cap);
  endtask

  // Random command mix, biased toward allocation so that new pages keep opening.
  task automatic send_mixed(input int count);
    int roll;
    logic [PAGE_W-1:0] pg;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (pages_level > 0 && $urandom_range(0, 99) < 85) begin
        pg = PAGE_W'($urandom_range(0, pages_level - 1));
      end else begin
        pg = PAGE_W'($urandom);
      end
      if (roll < 40) begin
        send_word(CMD_ALLOC, pick_slot(), pg, pick_size());
      end else if (roll < 62) begin
        send_word(CMD_RELEASE, pick_slot(), pg, pick_size());
      end else if (roll < 72) begin
        send_word(CMD_MAP, pick_slot(), pg, pick_size());
      end else if (roll < 80) begin
        send_word(CMD_UNMAP, pick_slot(), pg, pick_size());
      end else if (roll < 95) begin
        send_word(CMD_QUERY, pick_slot(), pg, pick_size());
      end else begin
        send_word(CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST)), pick_slot(), pg,
                  pick_size());
      end
    end
  endtask

  // Result side: random stall stretches, plus a long hold-off when one is asked for.
  initial begin : take_side
    int run;
    @(posedge clk);
    forever begin
      if (holds_served < hold_asks) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_served++;
      end else begin
        run = idle_len(take_style);
        if (run > 0) begin
          out_stall <= 1'b1;
          repeat (run) @(posedge clk);
        end
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      words_taken <= words_taken + 1;
    end
  end

  // Watchdog: too long without any word moving on either channel ends the run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int guard;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset settings: errors before any page exists, the first
    // page fill, field extremes, map and unmap, and out-of-range slots and pages.
    send_word(CMD_QUERY, '0, '0, '0);
    send_word(CMD_MAP, '0, '0, '0);
    send_word(CMD_RELEASE, '0, '0, '0);
    send_word(CMD_RSVD_FIRST, '0, '0, '0);
    send_word(CMD_RSVD_MID, '1, '0, '1);
    send_word(CMD_RSVD_LAST, '1, '1, '1);
    send_word(CMD_ALLOC, '0, '0, '0);
    send_word(CMD_ALLOC, '1, '1, SIZE_W'(BLK_MAX));
    send_word(CMD_ALLOC, '0, '0, '1);
    send_word(CMD_RELEASE, SLOT_W'(63), '0, '0);
    send_word(CMD_MAP, '0, '0, '0);
    send_word(CMD_QUERY, SLOT_W'(5), '0, '0);
    send_word(CMD_ALLOC, '0, '0, SIZE_W'(1));
    send_word(CMD_UNMAP, '0, '0, '0);
    send_word(CMD_QUERY, '0, '0, '0);
    send_word(CMD_MAP, '0, PAGE_W'(1), '0);
    send_word(CMD_UNMAP, '0, '1, '0);
    send_word(CMD_QUERY, SLOT_W'(64), '0, '0);
    send_word(CMD_RELEASE, '1, '0, '0);
    send_word(CMD_RELEASE, '0, '0, '0);

    // Random phases across a spread of register settings, extremes included.
    send_style = 1;
    configure(32'd1, 32'd5);
    send_mixed(70);

    send_style = 0;
    take_style = 0;
    configure(32'd65536, 32'd64);
    send_mixed(70);

    // The result side holds off while words keep coming, so the block backs up.
    take_style = 1;
    configure(32'd0, 32'd0);
    hold_asks++;
    send_mixed(70);

    send_style = 1;
    take_style = 0;
    configure(32'h0001_FFFF, 32'd127);
    send_mixed(70);

    take_style = 1;
    configure(DATA_W'($urandom_range(1, 65536)), DATA_W'($urandom_range(1, 64)));
    send_mixed(70);

    // One-slot pages: allocate until every page is open and the stack is empty,
    // then a few more that find no page left.
    configure(DATA_W'($urandom_range(1, 65536)), 32'd1);
    guard = 0;
    while (!(pages_level == POOL_PAGES && stack_level == 0) && guard < 1100) begin
      send_word(CMD_ALLOC, SLOT_W'($urandom), PAGE_W'($urandom), pick_size());
      guard++;
    end
    repeat (4) send_word(CMD_ALLOC, SLOT_W'($urandom), PAGE_W'($urandom), pick_size());

    // Release, with an occasional query, until the stack is full, then a few that find it full.
    send_style = 0;
    configure(32'd512, 32'd64);
    guard = 0;
    while (stack_level < STK_DEPTH && guard < 1200) begin
      if ($urandom_range(0, 15) == 0) begin
        send_word(CMD_QUERY, pick_slot(), PAGE_W'($urandom), pick_size());
      end else begin
        send_word(CMD_RELEASE, pick_slot(), PAGE_W'($urandom), pick_size());
      end
      guard++;
    end
    repeat (4) send_word(CMD_RELEASE, pick_slot(), PAGE_W'($urandom), pick_size());

    send_style = 1;
    configure(32'd4096, 32'd7);
    send_mixed(70);

    // Drain, leave time for any stray word, then have the checker look for leftovers.
    settle();
    drain_done <= 1'b1;
    @(posedge clk);
    drain_done <= 1'b0;
    @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/pbpa_pkg.sv
hw/rtl/pbpa_ram.sv
hw/rtl/pbpa_div.sv
hw/rtl/pbpa_seq.sv
hw/rtl/pbpa_dpath.sv
hw/rtl/paged_block_pool_allocator.sv
tb/pbpa_checker.sv
tb/tb_paged_block_pool_allocator.sv
